// ----- rtl/hb2_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hb2_pkg: shared types, constants and mixing functions
// Holds the word and key set types, the four nibble S-boxes and the WD16
// mixing function used by every step of the initialization pipeline.
// ----------------------------------------------------------------------------
package hb2_pkg;

    localparam int WORD_W          = 16;
    localparam int KEY_WORDS       = 8;
    localparam int IV_WORDS        = 4;
    localparam int STATE_WORDS     = 8;
    localparam int SET_WORDS       = 4;
    localparam int STEPS_PER_ROUND = 4;
    localparam int CFG_IDX_W       = $clog2(KEY_WORDS);
    localparam int INIT_ROUNDS_DEF = 4;

    typedef logic [WORD_W-1:0]       word_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
    typedef word_t [SET_WORDS-1:0]   key_set_t;
    typedef word_t [STATE_WORDS-1:0] state_t;

    typedef struct packed {
        state_t r;
        word_t  t;
    } stage_t;

    localparam logic [3:0] SBOX [0:3][0:15] = '{
        '{4'h7, 4'hc, 4'he, 4'h9, 4'h2, 4'h1, 4'h5, 4'hf,
          4'hb, 4'h6, 4'hd, 4'h0, 4'h4, 4'h8, 4'ha, 4'h3},
        '{4'h4, 4'ha, 4'h1, 4'h6, 4'h8, 4'hf, 4'h7, 4'hc,
          4'h3, 4'h0, 4'he, 4'hd, 4'h5, 4'h9, 4'hb, 4'h2},
        '{4'h2, 4'hf, 4'hc, 4'h1, 4'h5, 4'h6, 4'ha, 4'hd,
          4'he, 4'h8, 4'h3, 4'h4, 4'h0, 4'hb, 4'h9, 4'h7},
        '{4'hf, 4'h4, 4'h5, 4'h8, 4'h9, 4'h7, 4'h2, 4'h1,
          4'ha, 4'h3, 4'h0, 4'he, 4'h6, 4'hc, 4'hd, 4'hb}
    };

    function automatic word_t sub_layer(input word_t v);
        return {SBOX[0][v[15:12]], SBOX[1][v[11:8]], SBOX[2][v[7:4]], SBOX[3][v[3:0]]};
    endfunction

    function automatic word_t f_mix(input word_t v);
        word_t s;
        s = sub_layer(v);
        return s ^ {s[9:0], s[15:10]} ^ {s[5:0], s[15:6]};
    endfunction

    function automatic word_t wd16(input word_t x, input key_set_t k);
        word_t y;
        y = x;
        for (int n = 0; n < SET_WORDS; n++)
        begin
            y = f_mix(y ^ k[n]);
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lightweight_cipher_key_iv_init_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lightweight_cipher_key_iv_init_top: Hummingbird-2 key and IV initialization
// Loads the eight state words from a 64-bit IV and runs the initialization
// rounds under a 128-bit key, one WD16 mixing per pipeline stage.
//
// Usage:
// The eight key words are written through the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high and
// the key must only change while no transaction is in flight.
// An input transaction carries the four IV words and completes when in_valid
// is high and in_stall is low. An output transaction carries the eight state
// words and completes when out_valid is high and out_stall is low.
// Each WD16 mixing has its own registered pipeline stage. Throughput is one
// transaction per cycle while out_stall does not hold the pipeline.
// Reset clears all stage valid bits and the key words to zero.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module lightweight_cipher_key_iv_init_top #(
    parameter int INIT_ROUNDS = hb2_pkg::INIT_ROUNDS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire hb2_pkg::cfg_idx_t cfg_index,
    input  wire hb2_pkg::word_t    cfg_data,

    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire hb2_pkg::word_t    iv_word_1,
    input  wire hb2_pkg::word_t    iv_word_2,
    input  wire hb2_pkg::word_t    iv_word_3,
    input  wire hb2_pkg::word_t    iv_word_4,

    output      logic              out_valid,
    input  wire logic              out_stall,
    output      hb2_pkg::word_t    state_1,
    output      hb2_pkg::word_t    state_2,
    output      hb2_pkg::word_t    state_3,
    output      hb2_pkg::word_t    state_4,
    output      hb2_pkg::word_t    state_5,
    output      hb2_pkg::word_t    state_6,
    output      hb2_pkg::word_t    state_7,
    output      hb2_pkg::word_t    state_8
);

    import hb2_pkg::*;

    localparam int NUM_STAGES = INIT_ROUNDS * STEPS_PER_ROUND;

    word_t    key_reg [KEY_WORDS];
    key_set_t key_a;
    key_set_t key_b;

    stage_t   entry;
    stage_t   stage_in   [NUM_STAGES];
    stage_t   stage_next [NUM_STAGES];
    stage_t   pipe_reg   [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic     advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < KEY_WORDS; n++)
            begin
                key_reg[n] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int n = 0; n < SET_WORDS; n++)
        begin
            key_a[n] = key_reg[n];
            key_b[n] = key_reg[n + SET_WORDS];
        end
    end

    always_comb
    begin
        entry.r[0] = iv_word_1;
        entry.r[1] = iv_word_2;
        entry.r[2] = iv_word_3;
        entry.r[3] = iv_word_4;
        entry.r[4] = iv_word_1;
        entry.r[5] = iv_word_2;
        entry.r[6] = iv_word_3;
        entry.r[7] = iv_word_4;
        entry.t    = '0;
    end

    // The pipeline holds as a whole while a finished result waits.
    assign advance  = !(vld_reg[NUM_STAGES-1] && out_stall);
    assign in_stall = !advance;

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        localparam int    STEP = k % STEPS_PER_ROUND;
        localparam int    RND  = k / STEPS_PER_ROUND;
        localparam word_t RND_WORD = WORD_W'(RND);

        if (k == 0)
        begin : g_first
            assign stage_in[k] = entry;
        end
        else
        begin : g_chain
            assign stage_in[k] = pipe_reg[k-1];
        end

        if (STEP == 0)
        begin : g_t1
            word_t sum;
            always_comb
            begin
                sum = stage_in[k].r[0] + RND_WORD;
                stage_next[k]   = stage_in[k];
                stage_next[k].t = wd16(sum, key_a);
            end
        end
        else if (STEP == 1)
        begin : g_t2
            word_t sum;
            word_t rot;
            always_comb
            begin
                sum = stage_in[k].r[1] + stage_in[k].t;
                rot = {sum[0], sum[15:1]};
                stage_next[k]      = stage_in[k];
                stage_next[k].t    = wd16(sum, key_b);
                stage_next[k].r[1] = rot;
                stage_next[k].r[5] = stage_in[k].r[5] ^ rot;
            end
        end
        else if (STEP == 2)
        begin : g_t3
            word_t sum;
            word_t rot;
            always_comb
            begin
                sum = stage_in[k].r[2] + stage_in[k].t;
                rot = {sum[7:0], sum[15:8]};
                stage_next[k]      = stage_in[k];
                stage_next[k].t    = wd16(sum, key_a);
                stage_next[k].r[2] = rot;
                stage_next[k].r[6] = stage_in[k].r[6] ^ rot;
            end
        end
        else
        begin : g_t4
            word_t sum;
            word_t rot;
            word_t t4;
            word_t sum0;
            word_t rot0;
            always_comb
            begin
                sum  = stage_in[k].r[3] + stage_in[k].t;
                rot  = {sum[14:0], sum[15]};
                t4   = wd16(sum, key_b);
                sum0 = stage_in[k].r[0] + t4;
                rot0 = {sum0[12:0], sum0[15:13]};
                stage_next[k]      = stage_in[k];
                stage_next[k].t    = t4;
                stage_next[k].r[3] = rot;
                stage_next[k].r[7] = stage_in[k].r[7] ^ rot;
                stage_next[k].r[0] = rot0;
                stage_next[k].r[4] = stage_in[k].r[4] ^ rot0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                pipe_reg[k] <= stage_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NUM_STAGES-1];
    assign state_1   = pipe_reg[NUM_STAGES-1].r[0];
    assign state_2   = pipe_reg[NUM_STAGES-1].r[1];
    assign state_3   = pipe_reg[NUM_STAGES-1].r[2];
    assign state_4   = pipe_reg[NUM_STAGES-1].r[3];
    assign state_5   = pipe_reg[NUM_STAGES-1].r[4];
    assign state_6   = pipe_reg[NUM_STAGES-1].r[5];
    assign state_7   = pipe_reg[NUM_STAGES-1].r[6];
    assign state_8   = pipe_reg[NUM_STAGES-1].r[7];

endmodule
`default_nettype wire
